/* rtl/box_muller_gaussian_pair_core_assert.svh */
// Assertion macros, clocked on clk and disabled while rst_n is low.
`ifndef BOX_MULLER_GAUSSIAN_PAIR_CORE_ASSERT_SVH
`define BOX_MULLER_GAUSSIAN_PAIR_CORE_ASSERT_SVH

// cons must hold in the same cycle as ante
`define BMG_ASSERT_IMP(name, ante, cons, msg) \
    name: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// cond must never hold
`define BMG_ASSERT_NEVER(name, cond, msg) \
    name: assert property (@(posedge clk) disable iff (!rst_n) !(cond)) \
        else $error(msg);

`endif

/* rtl/bmg_pkg.sv */
package bmg_pkg;

    localparam int UNIFORM_BITS = 32;
    localparam int NORMAL_BITS  = 16;

    localparam int LOG_STEPS     = 32;
    localparam int SQRT_STEPS    = 20;
    localparam int HORNER_STEPS  = 5;

    localparam logic [31:0] UNI_MASK   = 32'((64'd1 << UNIFORM_BITS) - 64'd1);
    localparam logic [37:0] LOG_FULL   = 38'(UNIFORM_BITS) << 32;
    localparam logic [32:0] Q32_ONE    = 33'h1_0000_0000;
    localparam logic [30:0] TWO_LN2_Q30 = 31'd1488522236;
    localparam logic [32:0] PI_Q31     = 33'd6746518852;
    localparam logic [29:0] HALF_QUAD  = 30'h2000_0000;
    localparam logic [30:0] FULL_QUAD  = 31'h4000_0000;

    localparam logic [6:0] COS_DIV [HORNER_STEPS] = '{7'd90, 7'd56, 7'd30, 7'd12, 7'd2};
    localparam logic [6:0] SIN_DIV [HORNER_STEPS] = '{7'd1, 7'd72, 7'd42, 7'd20, 7'd6};
    localparam logic [31:0] COS_RCP [HORNER_STEPS] = '{
        32'((64'd1 << 32) / 64'd90), 32'((64'd1 << 32) / 64'd56),
        32'((64'd1 << 32) / 64'd30), 32'((64'd1 << 32) / 64'd12),
        32'((64'd1 << 32) / 64'd2)};
    localparam logic [31:0] SIN_RCP [HORNER_STEPS] = '{
        32'hFFFF_FFFF, 32'((64'd1 << 32) / 64'd72),
        32'((64'd1 << 32) / 64'd42), 32'((64'd1 << 32) / 64'd20),
        32'((64'd1 << 32) / 64'd6)};

    localparam logic [1:0] QUAD_0 = 2'd0;
    localparam logic [1:0] QUAD_1 = 2'd1;
    localparam logic [1:0] QUAD_2 = 2'd2;
    localparam logic [1:0] QUAD_3 = 2'd3;

    localparam int SAT_W = ((NORMAL_BITS > 18) ? NORMAL_BITS : 18) + 1;
    localparam logic signed [SAT_W-1:0] OUT_MAX =
        SAT_W'((64'sd1 <<< (NORMAL_BITS - 1)) - 64'sd1);
    localparam logic signed [SAT_W-1:0] OUT_MIN = -OUT_MAX - SAT_W'(1);

    // pipeline stage numbers
    localparam int ST_IN      = 0;
    localparam int ST_NORM    = 1;
    localparam int ST_EL      = ST_NORM + LOG_STEPS + 1;
    localparam int ST_TQ      = ST_EL + 1;
    localparam int ST_SQ_END  = ST_TQ + SQRT_STEPS;
    localparam int ST_RED     = ST_SQ_END + 1;
    localparam int ST_ANG     = ST_RED + 1;
    localparam int ST_SQ      = ST_ANG + 1;
    localparam int ST_TRIG    = ST_SQ + 3 * HORNER_STEPS + 1;
    localparam int ST_MUL     = ST_TRIG + 1;
    localparam int ST_OUT     = ST_MUL + 1;
    localparam int NSTAGE     = ST_OUT + 1;
    localparam int LATENCY    = ST_OUT + 1;

    localparam int RAD_LEN = ST_MUL - ST_RED;
    localparam int ANG_LEN = ST_TRIG - ST_ANG;
    localparam int SQL_LEN = 3 * (HORNER_STEPS - 1) + 1;

    typedef struct packed {
        logic        last;
        logic [31:0] phase;
    } bmg_ctx_t;

endpackage

/* rtl/box_muller_gaussian_pair_core.sv */
// Box-Muller Gaussian pair generator. One item (two uniform codes and a last
// flag) is taken per clock: busy is always low. Each item gives one pair of
// normal samples, signed with 12 fraction bits, on normal_cos/normal_sin with
// last_out. strobe marks them for one cycle. Results cannot be held off; the
// receiver must take every strobe. Latency is set by the 32-step log2 squaring
// chain and the 20-step square root, one step per stage, and by the 5-step
// cosine series (4 steps for sine) at three stages per step (multiply,
// reciprocal multiply, correct).
`include "box_muller_gaussian_pair_core_assert.svh"

module box_muller_gaussian_pair_core
    import bmg_pkg::*;
(
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          start,
    output logic                          busy,
    input  logic [31:0]                   uniform_radius,
    input  logic [31:0]                   uniform_angle,
    input  logic                          last_pair,
    output logic                          strobe,
    output logic signed [NORMAL_BITS-1:0] normal_cos,
    output logic signed [NORMAL_BITS-1:0] normal_sin,
    output logic                          last_out
);

    logic     v_reg   [NSTAGE];
    bmg_ctx_t ctx_reg [NSTAGE];

    logic [32:0] in_m_reg;

    logic [31:0] lg_mant_reg [LOG_STEPS+1];
    logic [31:0] lg_frac_reg [LOG_STEPS+1];
    logic [5:0]  lg_e_reg    [LOG_STEPS+1];

    logic [29:0] el_sh_reg;

    logic [39:0] sq_v_reg [SQRT_STEPS+1];
    logic [39:0] sq_r_reg [SQRT_STEPS+1];

    logic [19:0] rad_reg [RAD_LEN];
    logic [29:0] red_off_reg;
    logic [31:0] ang_reg [ANG_LEN];
    logic [31:0] sql_reg [SQL_LEN];

    logic [31:0] hp_c_reg  [HORNER_STEPS];
    logic [31:0] hpd_c_reg [HORNER_STEPS];
    logic [63:0] hm_c_reg  [HORNER_STEPS];
    logic [32:0] ha_c_reg  [HORNER_STEPS];
    logic [31:0] hp_s_reg  [1:HORNER_STEPS-1];
    logic [31:0] hpd_s_reg [1:HORNER_STEPS-1];
    logic [63:0] hm_s_reg  [1:HORNER_STEPS-1];
    logic [32:0] ha_s_reg  [1:HORNER_STEPS-1];

    logic [31:0] sin_reg;
    logic [32:0] cos_reg;
    logic [52:0] m0_reg, m1_reg;
    logic        neg0_reg, neg1_reg;

    logic signed [NORMAL_BITS-1:0] out_cos_reg, out_sin_reg;

    assign busy = 1'b0;

    // ---------------- control line ----------------
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v_reg[ST_IN] <= 1'b0;
        end
        else
        begin
            v_reg[ST_IN] <= start && !busy;
        end
    end

    always_ff @(posedge clk)
    begin
        ctx_reg[ST_IN].last  <= last_pair;
        ctx_reg[ST_IN].phase <= uniform_angle << (32 - UNIFORM_BITS);
        in_m_reg             <= 33'(uniform_radius & UNI_MASK) + 33'd1;
    end

    for (genvar s = 1; s < NSTAGE; s++)
    begin : g_line
        always_ff @(posedge clk or negedge rst_n)
        begin
            if (!rst_n)
            begin
                v_reg[s] <= 1'b0;
            end
            else
            begin
                v_reg[s] <= v_reg[s-1];
            end
        end

        always_ff @(posedge clk)
        begin
            ctx_reg[s] <= ctx_reg[s-1];
        end
    end

    // ---------------- log2: normalize ----------------
    logic [5:0]  norm_e;
    logic [31:0] norm_mant;

    always_comb
    begin
        norm_e = '0;
        for (int i = 0; i < 33; i++)
        begin
            if (in_m_reg[i])
            begin
                norm_e = 6'(i);
            end
        end
        if (norm_e <= 6'd31)
        begin
            norm_mant = 32'(in_m_reg << (6'd31 - norm_e));
        end
        else
        begin
            norm_mant = in_m_reg[32:1];
        end
    end

    always_ff @(posedge clk)
    begin
        lg_mant_reg[0] <= norm_mant;
        lg_frac_reg[0] <= '0;
        lg_e_reg[0]    <= norm_e;
    end

    // ---------------- log2: one fraction bit per stage ----------------
    for (genvar i = 0; i < LOG_STEPS; i++)
    begin : g_log
        logic [63:0] pr;
        logic [32:0] sq33;

        assign pr   = 64'(lg_mant_reg[i]) * 64'(lg_mant_reg[i]);
        assign sq33 = pr[63:31];

        always_ff @(posedge clk)
        begin
            lg_mant_reg[i+1] <= sq33[32] ? sq33[32:1] : sq33[31:0];
            lg_frac_reg[i+1] <= {lg_frac_reg[i][30:0], sq33[32]};
            lg_e_reg[i+1]    <= lg_e_reg[i];
        end
    end

    // ---------------- -2 ln u1 ----------------
    logic [37:0] lg_full;
    logic [37:0] el;
    logic [60:0] tq_prod;

    assign lg_full = {lg_e_reg[LOG_STEPS], lg_frac_reg[LOG_STEPS]};
    assign el      = (LOG_FULL > lg_full) ? (LOG_FULL - lg_full) : '0;
    assign tq_prod = 61'(el_sh_reg) * 61'(TWO_LN2_Q30);

    always_ff @(posedge clk)
    begin
        el_sh_reg   <= el[37:8];
        sq_v_reg[0] <= 40'(tq_prod[60:22]);
        sq_r_reg[0] <= '0;
    end

    // ---------------- square root, one result bit per stage ----------------
    for (genvar j = 0; j < SQRT_STEPS; j++)
    begin : g_sqrt
        localparam logic [39:0] SBIT = 40'd1 << (38 - 2 * j);
        logic [39:0] trial;
        logic        ge;

        assign trial = sq_r_reg[j] + SBIT;
        assign ge    = sq_v_reg[j] >= trial;

        always_ff @(posedge clk)
        begin
            sq_v_reg[j+1] <= ge ? (sq_v_reg[j] - trial) : sq_v_reg[j];
            sq_r_reg[j+1] <= ge ? ((sq_r_reg[j] >> 1) + SBIT) : (sq_r_reg[j] >> 1);
        end
    end

    // ---------------- radius carry line ----------------
    always_ff @(posedge clk)
    begin
        rad_reg[0] <= sq_r_reg[SQRT_STEPS][19:0];
    end

    for (genvar n = 1; n < RAD_LEN; n++)
    begin : g_rad
        always_ff @(posedge clk)
        begin
            rad_reg[n] <= rad_reg[n-1];
        end
    end

    // ---------------- angle reduction ----------------
    logic [29:0] off_in;
    logic        red_flip;
    logic [62:0] ang_prod;
    logic [63:0] sq_prod;

    assign off_in   = ctx_reg[ST_SQ_END].phase[29:0];
    assign red_flip = off_in > HALF_QUAD;
    assign ang_prod = 63'(red_off_reg) * 63'(PI_Q31);
    assign sq_prod  = 64'(ang_reg[0]) * 64'(ang_reg[0]);

    always_ff @(posedge clk)
    begin
        red_off_reg <= red_flip ? 30'(FULL_QUAD - 31'(off_in)) : off_in;
        ang_reg[0]  <= ang_prod[61:30];
        sql_reg[0]  <= sq_prod[63:32];
    end

    for (genvar n = 1; n < ANG_LEN; n++)
    begin : g_ang
        always_ff @(posedge clk)
        begin
            ang_reg[n] <= ang_reg[n-1];
        end
    end

    for (genvar n = 1; n < SQL_LEN; n++)
    begin : g_sql
        always_ff @(posedge clk)
        begin
            sql_reg[n] <= sql_reg[n-1];
        end
    end

    // ---------------- Horner steps: multiply, reciprocal, correct ----------------
    for (genvar k = 0; k < HORNER_STEPS; k++)
    begin : g_horner
        logic [32:0] a_c_prev;
        logic [64:0] p_c;
        logic [31:0] q0_c;
        logic [39:0] r_c;
        logic [31:0] q_c;

        if (k == 0)
        begin : g_first
            assign a_c_prev = Q32_ONE;
        end
        else
        begin : g_next
            assign a_c_prev = ha_c_reg[k-1];
        end

        assign p_c  = 65'(sql_reg[3*k]) * 65'(a_c_prev);
        assign q0_c = hm_c_reg[k][63:32];
        assign r_c  = 40'(hpd_c_reg[k]) - 40'(q0_c) * 40'(COS_DIV[k]);
        assign q_c  = (r_c >= 40'(COS_DIV[k])) ? (q0_c + 32'd1) : q0_c;

        always_ff @(posedge clk)
        begin
            hp_c_reg[k]  <= p_c[63:32];
            hm_c_reg[k]  <= 64'(hp_c_reg[k]) * 64'(COS_RCP[k]);
            hpd_c_reg[k] <= hp_c_reg[k];
            ha_c_reg[k]  <= Q32_ONE - 33'(q_c);
        end

        if (k > 0)
        begin : g_sin
            logic [32:0] a_s_prev;
            logic [64:0] p_s;
            logic [31:0] q0_s;
            logic [39:0] r_s;
            logic [31:0] q_s;

            if (k == 1)
            begin : g_first
                assign a_s_prev = Q32_ONE;
            end
            else
            begin : g_next
                assign a_s_prev = ha_s_reg[k-1];
            end

            assign p_s  = 65'(sql_reg[3*k]) * 65'(a_s_prev);
            assign q0_s = hm_s_reg[k][63:32];
            assign r_s  = 40'(hpd_s_reg[k]) - 40'(q0_s) * 40'(SIN_DIV[k]);
            assign q_s  = (r_s >= 40'(SIN_DIV[k])) ? (q0_s + 32'd1) : q0_s;

            always_ff @(posedge clk)
            begin
                hp_s_reg[k]  <= p_s[63:32];
                hm_s_reg[k]  <= 64'(hp_s_reg[k]) * 64'(SIN_RCP[k]);
                hpd_s_reg[k] <= hp_s_reg[k];
                ha_s_reg[k]  <= Q32_ONE - 33'(q_s);
            end
        end
    end

    // ---------------- sine product, quadrant mapping, scaling ----------------
    logic [64:0] sin_prod;
    logic [31:0] trig_phase;
    logic        trig_flip;
    logic [32:0] s0, c0, t0, t1;
    logic        n0, n1;

    assign sin_prod   = 65'(ang_reg[ANG_LEN-1]) * 65'(ha_s_reg[HORNER_STEPS-1]);
    assign trig_phase = ctx_reg[ST_TRIG].phase;
    assign trig_flip  = trig_phase[29:0] > HALF_QUAD;
    assign s0         = trig_flip ? cos_reg : 33'(sin_reg);
    assign c0         = trig_flip ? 33'(sin_reg) : cos_reg;

    always_comb
    begin
        case (trig_phase[31:30])
            QUAD_0:
            begin
                t0 = c0; n0 = 1'b0; t1 = s0; n1 = 1'b0;
            end
            QUAD_1:
            begin
                t0 = s0; n0 = 1'b1; t1 = c0; n1 = 1'b0;
            end
            QUAD_2:
            begin
                t0 = c0; n0 = 1'b1; t1 = s0; n1 = 1'b1;
            end
            QUAD_3:
            begin
                t0 = s0; n0 = 1'b0; t1 = c0; n1 = 1'b1;
            end
            default:
            begin
                t0 = c0; n0 = 1'b0; t1 = s0; n1 = 1'b0;
            end
        endcase
    end

    always_ff @(posedge clk)
    begin
        sin_reg  <= sin_prod[63:32];
        cos_reg  <= ha_c_reg[HORNER_STEPS-1];
        m0_reg   <= 53'(rad_reg[RAD_LEN-1]) * 53'(t0);
        m1_reg   <= 53'(rad_reg[RAD_LEN-1]) * 53'(t1);
        neg0_reg <= n0;
        neg1_reg <= n1;
    end

    // ---------------- round, sign, saturate ----------------
    logic [52:0] rnd0, rnd1;
    logic signed [SAT_W-1:0] v0, v1, w0, w1;

    always_comb
    begin
        rnd0 = m0_reg + (53'd1 << 35);
        rnd1 = m1_reg + (53'd1 << 35);
        v0   = SAT_W'(rnd0[52:36]);
        v1   = SAT_W'(rnd1[52:36]);
        if (neg0_reg)
        begin
            v0 = -v0;
        end
        if (neg1_reg)
        begin
            v1 = -v1;
        end
        w0 = (v0 > OUT_MAX) ? OUT_MAX : ((v0 < OUT_MIN) ? OUT_MIN : v0);
        w1 = (v1 > OUT_MAX) ? OUT_MAX : ((v1 < OUT_MIN) ? OUT_MIN : v1);
    end

    always_ff @(posedge clk)
    begin
        out_cos_reg <= NORMAL_BITS'(w0);
        out_sin_reg <= NORMAL_BITS'(w1);
    end

    assign strobe     = v_reg[ST_OUT];
    assign last_out   = ctx_reg[ST_OUT].last;
    assign normal_cos = out_cos_reg;
    assign normal_sin = out_sin_reg;

    // ---------------- assertions ----------------
    `BMG_ASSERT_IMP(a_latency, strobe, $past(start && !busy, LATENCY), "strobe without item")
    `BMG_ASSERT_IMP(a_last, strobe, last_out == $past(last_pair, LATENCY), "last flag mismatch")
    `BMG_ASSERT_IMP(a_unit_radius, strobe && $past(&uniform_radius[UNIFORM_BITS-1:0], LATENCY), (normal_cos == '0) && (normal_sin == '0), "nonzero output for unit radius")
    `BMG_ASSERT_IMP(a_sqrt_rem, v_reg[ST_SQ_END], sq_v_reg[SQRT_STEPS] <= (sq_r_reg[SQRT_STEPS] << 1), "square root remainder too large")
    `BMG_ASSERT_NEVER(a_busy, busy, "busy raised")

endmodule
